// ===== rtl/trt_pkg.sv =====
// ----------------------------------------------------------------------------
// trt_pkg: shared types and constants of the text run tokenizer
// Token kinds, configuration register indexes, result types and the byte
// classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package trt_pkg;

    // token kinds
    localparam logic [2:0] K_BLANK = 3'd0;
    localparam logic [2:0] K_WORD  = 3'd1;
    localparam logic [2:0] K_PUNCT = 3'd2;
    localparam logic [2:0] K_ENDL  = 3'd3;
    localparam logic [2:0] K_TERM  = 3'd4;

    // configuration register indexes
    localparam int         CFG_IDX_W      = 1;
    localparam int         CFG_DATA_W     = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_EN   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_BYTE = 1'd1;

    localparam logic [7:0] ESC_BYTE_RST = 8'd92;

    // emit counts
    localparam logic [1:0] EMIT_NONE = 2'd0;
    localparam logic [1:0] EMIT_ONE  = 2'd1;
    localparam logic [1:0] EMIT_TWO  = 2'd2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] kind;
        logic       token_start;
        logic       run_last;
    } t_result;

    // results caused by one request
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_emit;

    function automatic logic [2:0] trt_classify(input logic [7:0] c);
        logic [2:0] k;
        if (c == 8'h09 || c == 8'h20) begin
            k = K_BLANK;
        end else if (c >= 8'h80) begin
            k = K_WORD;
        end else if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                     (c >= 8'h61 && c <= 8'h7A)) begin
            k = K_WORD;
        end else if (c >= 8'h21 && c <= 8'h7E) begin
            k = K_PUNCT;
        end else if (c >= 8'h0A && c <= 8'h0D) begin
            k = K_ENDL;
        end else begin
            k = K_TERM;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/trt_in_if.sv =====
// ----------------------------------------------------------------------------
// trt_in_if: input byte channel
// Valid/ready channel that carries one text byte and its end-of-stream flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface trt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_end;

    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/trt_out_if.sv =====
// ----------------------------------------------------------------------------
// trt_out_if: result channel
// Valid/ready channel that carries one classified output byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface trt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic       token_start;
    logic       run_last;

    modport source (output valid, output out_byte, output kind, output token_start,
                    output run_last, input ready);
    modport sink   (input valid, input out_byte, input kind, input token_start,
                    input run_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/trt_lexer.sv =====
// ----------------------------------------------------------------------------
// trt_lexer: run merge and escape decision
// Holds the token state and the configuration registers, and works out the
// results of one accepted request combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module trt_lexer
    import trt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_accept,
    input  wire logic [7:0]            i_byte,
    input  wire logic                  i_last,
    output t_emit                      o_emit
);

    logic       r_esc_en;
    logic [7:0] r_esc_byte;
    logic [2:0] r_prev_kind, n_prev_kind;
    logic [7:0] r_prev_byte, n_prev_byte;
    logic       r_esc_pend,  n_esc_pend;
    logic       r_open,      n_open;
    logic       r_empty,     n_empty;

    logic [2:0] cls;
    logic       joins;
    t_emit      emit;

    assign cls   = trt_classify(i_byte);
    assign joins = r_open && (cls == r_prev_kind) &&
                   !(r_prev_kind == K_PUNCT && r_prev_byte != i_byte);

    // decide results and next token state
    always_comb begin
        emit        = '0;
        n_prev_kind = r_prev_kind;
        n_prev_byte = r_prev_byte;
        n_esc_pend  = r_esc_pend;
        n_open      = r_open;
        n_empty     = r_empty;

        if (r_esc_pend) begin
            n_esc_pend  = 1'b0;
            n_empty     = 1'b0;
            n_open      = 1'b1;
            n_prev_kind = K_WORD;
            n_prev_byte = i_byte;
            if (cls == K_WORD || cls == K_BLANK) begin
                emit.count = EMIT_TWO;
                emit.r0    = '{out_byte: r_esc_byte, kind: K_WORD, token_start: 1'b1,
                               run_last: 1'b0};
                emit.r1    = '{out_byte: i_byte, kind: K_WORD, token_start: 1'b0,
                               run_last: 1'b1};
            end else if (cls == K_PUNCT) begin
                emit.count = EMIT_ONE;
                emit.r0    = '{out_byte: i_byte, kind: K_WORD, token_start: 1'b1,
                               run_last: 1'b1};
            end else if (cls == K_ENDL) begin
                emit.count  = EMIT_TWO;
                emit.r0     = '{out_byte: i_byte, kind: K_ENDL, token_start: 1'b1,
                                run_last: 1'b0};
                emit.r1     = '{out_byte: i_byte, kind: K_ENDL, token_start: 1'b0,
                                run_last: 1'b1};
                n_prev_kind = K_ENDL;
            end else begin
                // escaped terminator opens an empty word token
                n_empty = 1'b1;
            end
        end else if (joins) begin
            emit.count  = EMIT_ONE;
            emit.r0     = '{out_byte: i_byte, kind: cls, token_start: r_empty,
                            run_last: 1'b1};
            n_empty     = 1'b0;
            n_prev_byte = i_byte;
        end else if (r_esc_en && i_byte == r_esc_byte) begin
            n_open      = 1'b0;
            n_empty     = 1'b0;
            n_prev_kind = K_TERM;
            if (i_last) begin
                emit.count = EMIT_ONE;
                emit.r0    = '{out_byte: i_byte, kind: K_WORD, token_start: 1'b1,
                               run_last: 1'b1};
            end else begin
                n_esc_pend = 1'b1;
            end
        end else begin
            emit.count  = EMIT_ONE;
            emit.r0     = '{out_byte: i_byte, kind: cls, token_start: 1'b1,
                            run_last: 1'b1};
            n_open      = 1'b1;
            n_empty     = 1'b0;
            n_prev_kind = cls;
            n_prev_byte = i_byte;
        end

        // end of stream drops all token state
        if (i_last) begin
            n_prev_kind = K_TERM;
            n_prev_byte = 8'd0;
            n_esc_pend  = 1'b0;
            n_open      = 1'b0;
            n_empty     = 1'b0;
        end
    end

    assign o_emit = emit;

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_en   <= 1'b1;
            r_esc_byte <= ESC_BYTE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ESC_EN:   r_esc_en   <= i_cfg_data[0];
                CFG_ESC_BYTE: r_esc_byte <= i_cfg_data;
                default:      r_esc_en   <= r_esc_en;
            endcase
        end
    end

    // advance token state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_kind <= K_TERM;
            r_prev_byte <= 8'd0;
            r_esc_pend  <= 1'b0;
            r_open      <= 1'b0;
            r_empty     <= 1'b0;
        end else if (i_accept) begin
            r_prev_kind <= n_prev_kind;
            r_prev_byte <= n_prev_byte;
            r_esc_pend  <= n_esc_pend;
            r_open      <= n_open;
            r_empty     <= n_empty;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/text_run_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// text_run_tokenizer_top: character class run lexer
// Classifies text bytes, merges runs into tokens and resolves escape pairs.
// ----------------------------------------------------------------------------
// Results are registered: a request's first result appears on the output in
// the cycle after the request. One request per cycle while the output is ready
// and each yields at most one result; a request that yields two results holds
// the input until the two-entry result buffer has drained to one entry.
// Reset: synchronous active low; clears token state, empties the result
// buffer and restores escape_enable to 1 and escape_byte to 92.
`default_nettype none

module text_run_tokenizer_top
    import trt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    trt_in_if.sink                     i_req,
    trt_out_if.source                  o_rsp
);

    logic [1:0] r_cnt, n_cnt;
    t_result    r_slot0, n_slot0;
    t_result    r_slot1, n_slot1;

    logic  accept;
    logic  pop;
    t_emit emit;

    assign pop         = o_rsp.valid && o_rsp.ready;
    assign i_req.ready = (r_cnt == EMIT_NONE) || (r_cnt == EMIT_ONE && o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;

    trt_lexer u_lexer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_byte     (i_req.in_byte),
        .i_last     (i_req.stream_end),
        .o_emit     (emit)
    );

    // load new results or shift the buffer on a pop
    always_comb begin
        n_cnt   = r_cnt;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (accept) begin
            n_cnt   = emit.count;
            n_slot0 = emit.r0;
            n_slot1 = emit.r1;
            if (!pop && r_cnt == EMIT_ONE) begin
                n_cnt = r_cnt;
            end
        end else if (pop) begin
            n_cnt   = r_cnt - 2'd1;
            n_slot0 = r_slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= EMIT_NONE;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    // drive the result channel from the head slot
    assign o_rsp.valid       = (r_cnt != EMIT_NONE);
    assign o_rsp.out_byte    = r_slot0.out_byte;
    assign o_rsp.kind        = r_slot0.kind;
    assign o_rsp.token_start = r_slot0.token_start;
    assign o_rsp.run_last    = r_slot0.run_last;

endmodule

`default_nettype wire
